/* rtl/mds_pkg.sv */
// ---------------------------------------------------------------------------
// Multibyte delimiter splitter package
// Shared constants, register indexes and the segment result type.
// ---------------------------------------------------------------------------
`default_nettype none

package mds_pkg;

    localparam int MAX_DELIM_BYTES  = 8;
    localparam int WINDOW_BYTES     = 8;
    localparam int DELIM_CAP        = (MAX_DELIM_BYTES < WINDOW_BYTES) ?
                                      MAX_DELIM_BYTES : WINDOW_BYTES;
    localparam int MAX_STRING_BYTES = 65536;
    localparam int POS_W            = $clog2(MAX_STRING_BYTES + 1);
    localparam int START_W          = 16;
    localparam int LENGTH_W         = 17;
    localparam int START_CAP        = 65535;
    localparam int LENGTH_CAP       = 65536;
    localparam int DLEN_W           = 4;
    localparam int DELIM_W          = 8 * WINDOW_BYTES;
    localparam int RECENT_W         = 8 * (WINDOW_BYTES - 1);
    localparam int CFG_W            = 64;
    localparam int CFG_IDX_W        = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'b1;

    localparam logic [DELIM_W-1:0] DELIM_BYTES_RESET  = DELIM_W'(32);
    localparam logic [DLEN_W-1:0]  DELIM_LENGTH_RESET = DLEN_W'(1);

    typedef struct packed {
        logic                too_long;
        logic                last;
        logic [LENGTH_W-1:0] length;
        logic [START_W-1:0]  start;
    } seg_result_t;

endpackage

`default_nettype wire

/* rtl/mds_match.sv */
// ---------------------------------------------------------------------------
// Delimiter window match
// Compares the newest bytes of the window against the configured delimiter.
// ---------------------------------------------------------------------------
`default_nettype none

module mds_match (
    input  wire logic [mds_pkg::DELIM_W-1:0] window,
    input  wire logic [mds_pkg::DELIM_W-1:0] delim_bytes,
    input  wire logic [mds_pkg::DLEN_W-1:0]  delim_length,
    output logic      [mds_pkg::DLEN_W-1:0]  eff_len,
    output logic                             match
);
    import mds_pkg::*;

    logic [5:0]              shamt;
    logic [DELIM_W-1:0]      aligned;
    logic [WINDOW_BYTES-1:0] byte_ok;

    always_comb
    begin
        if (delim_length == '0)
        begin
            eff_len = DLEN_W'(1);
        end
        else if (32'(delim_length) > DELIM_CAP)
        begin
            eff_len = DLEN_W'(DELIM_CAP);
        end
        else
        begin
            eff_len = delim_length;
        end
    end

    // The newest byte of a match lands in the lowest used lane after alignment.
    assign shamt   = 6'((WINDOW_BYTES - int'(eff_len)) * 8);
    assign aligned = window << shamt;

    always_comb
    begin
        for (int i = 0; i < WINDOW_BYTES; i++)
        begin
            byte_ok[i] = (DLEN_W'(i) >= eff_len) ||
                         (delim_bytes[8*i +: 8] == aligned[8*(WINDOW_BYTES-1-i) +: 8]);
        end
    end

    assign match = &byte_ok;

endmodule

`default_nettype wire

/* rtl/mds_core.sv */
// ---------------------------------------------------------------------------
// Splitter core
// Holds the per-string state and forms at most one segment result per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module mds_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          byte_present,
    input  wire logic                          string_end,
    input  wire logic [mds_pkg::DELIM_W-1:0]   delim_bytes,
    input  wire logic [mds_pkg::DLEN_W-1:0]    delim_length,
    output logic                               emit,
    output mds_pkg::seg_result_t               result
);
    import mds_pkg::*;

    logic [RECENT_W-1:0] recent_reg, recent_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    begin_reg, begin_next;
    logic                ovf_reg, ovf_next;

    logic [DELIM_W-1:0]  window;
    logic [DLEN_W-1:0]   eff_len;
    logic                pattern_hit;
    logic                full;
    logic                counted;
    logic [POS_W-1:0]    next_pos;
    logic [POS_W-1:0]    span;
    logic                hit;
    logic [POS_W-1:0]    seg_len;

    assign window = {recent_reg, data_byte};

    mds_match u_match (
        .window       (window),
        .delim_bytes  (delim_bytes),
        .delim_length (delim_length),
        .eff_len      (eff_len),
        .match        (pattern_hit)
    );

    assign full     = (32'(pos_reg) >= MAX_STRING_BYTES);
    assign counted  = byte_present && !full;
    assign next_pos = counted ? pos_reg + POS_W'(1) : pos_reg;
    assign span     = next_pos - begin_reg;
    assign hit      = counted && !ovf_reg && (span >= POS_W'(eff_len)) && pattern_hit;
    assign seg_len  = hit ? span - POS_W'(eff_len) : span;
    assign emit     = hit || string_end;

    always_comb
    begin
        result.start    = (32'(begin_reg) > START_CAP) ? START_W'(START_CAP)
                                                       : START_W'(begin_reg);
        result.length   = (32'(seg_len) > LENGTH_CAP) ? LENGTH_W'(LENGTH_CAP)
                                                      : LENGTH_W'(seg_len);
        result.last     = string_end;
        result.too_long = ovf_reg || (byte_present && full);
    end

    always_comb
    begin
        recent_next = recent_reg;
        pos_next    = pos_reg;
        begin_next  = begin_reg;
        ovf_next    = ovf_reg;
        if (string_end)
        begin
            recent_next = '0;
            pos_next    = '0;
            begin_next  = '0;
            ovf_next    = 1'b0;
        end
        else
        begin
            if (byte_present)
            begin
                recent_next = window[RECENT_W-1:0];
            end
            if (byte_present && full)
            begin
                ovf_next = 1'b1;
            end
            pos_next = next_pos;
            if (hit)
            begin
                begin_next = next_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
            pos_reg    <= '0;
            begin_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            recent_reg <= recent_next;
            pos_reg    <= pos_next;
            begin_reg  <= begin_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/multibyte_delimiter_splitter_unit.sv */
// ---------------------------------------------------------------------------
// Multibyte delimiter splitter
// Splits a byte stream on a configurable delimiter of one to eight bytes.
// ---------------------------------------------------------------------------
// A byte is accepted on every clock while the output register is empty or
// being drained; the match, the segment arithmetic and the state update
// are combinational and are registered when the byte is accepted, and a
// segment appears on the output in the cycle after the byte that closes it.
// The rate is set by the single output register, which stalls the input
// only while a result waits and the downstream side is not ready.
// ---------------------------------------------------------------------------
`default_nettype none

module multibyte_delimiter_splitter_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [mds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mds_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,   // data_byte
    input  wire logic                           s_axis_tuser,   // byte_present
    input  wire logic                           s_axis_tlast,   // string_end
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [39:0]                         m_axis_tdata,   // segment_start, segment_length
    output logic                                m_axis_tuser,   // too_long
    output logic                                m_axis_tlast    // segment_last
);
    import mds_pkg::*;

    logic [DELIM_W-1:0] delim_bytes_reg;
    logic [DLEN_W-1:0]  delim_length_reg;
    logic               out_valid_reg, out_valid_next;
    seg_result_t        out_data_reg;

    logic               accept;
    logic               emit;
    seg_result_t        result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_bytes_reg  <= DELIM_BYTES_RESET;
            delim_length_reg <= DELIM_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DELIM_BYTES:  delim_bytes_reg  <= cfg_data[DELIM_W-1:0];
                REG_DELIM_LENGTH: delim_length_reg <= cfg_data[DLEN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mds_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (s_axis_tdata),
        .byte_present (s_axis_tuser),
        .string_end   (s_axis_tlast),
        .delim_bytes  (delim_bytes_reg),
        .delim_length (delim_length_reg),
        .emit         (emit),
        .result       (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_data_reg.length, out_data_reg.start};
    assign m_axis_tuser  = out_data_reg.too_long;
    assign m_axis_tlast  = out_data_reg.last;

endmodule

`default_nettype wire

/* rtl/mds_checker.sv */
// ---------------------------------------------------------------------------
// Splitter port checker
// Concurrent checks on the port behavior of the splitter top level.
// ---------------------------------------------------------------------------
`default_nettype none

module mds_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata
);

    // A pending result stays until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    // The input side is open exactly when the output register can take a result.
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output register state");

    // Every string end produces a final segment in the next cycle.
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
        else $error("string end gave no segment");

    // Segment length is bounded and the padding bits are zero.
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32:16] <= 17'd65536) && (m_axis_tdata[39:33] == 7'd0))
        else $error("segment length out of range");

endmodule

bind multibyte_delimiter_splitter_unit mds_checker u_mds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// Multibyte delimiter splitter testbench
// Streams strings byte by byte into the splitter under several delimiter
// settings and checks every segment transaction against a cycle-free
// prediction of the leftmost, non-overlapping split, including strings
// that reach and pass the maximum supported length.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mds_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned IDLE_PERCENT = 35;
    localparam int unsigned PHASE_ITEMS  = 150;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       ending;
    } text_item_t;

    class segment_scoreboard;
        logic [DELIM_W-1:0]  delim_bytes;
        logic [DLEN_W-1:0]   delim_length;
        logic [RECENT_W-1:0] recent_bytes;
        int unsigned         byte_position;
        int unsigned         segment_begin;
        bit                  overflow_seen;
        seg_result_t         expected_segments[$];
        int unsigned         failures;

        function new();
            delim_bytes  = DELIM_BYTES_RESET;
            delim_length = DELIM_LENGTH_RESET;
            failures     = 0;
            clear_string();
        endfunction

        function void clear_string();
            recent_bytes  = '0;
            byte_position = 0;
            segment_begin = 0;
            overflow_seen = 1'b0;
        endfunction

        function int unsigned delim_span();
            int unsigned span;
            span = delim_length;
            if (span == 0)
                span = 1;
            if (span > DELIM_CAP)
                span = DELIM_CAP;
            return span;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
            if (index == REG_DELIM_BYTES)
                delim_bytes = value[DELIM_W-1:0];
            else if (index == REG_DELIM_LENGTH)
                delim_length = value[DLEN_W-1:0];
        endfunction

        function void push_segment(int unsigned start, int unsigned length, bit last);
            seg_result_t seg;
            seg.start    = START_W'((start > START_CAP) ? START_CAP : start);
            seg.length   = LENGTH_W'((length > LENGTH_CAP) ? LENGTH_CAP : length);
            seg.last     = last;
            seg.too_long = overflow_seen;
            expected_segments.push_back(seg);
        endfunction

        function void note_byte(logic [7:0] data, logic present, logic ending);
            logic [DELIM_W-1:0] window;
            int unsigned        span;
            int unsigned        next_pos;
            int unsigned        i;
            bit                 hit;
            if (present)
            begin
                window       = {recent_bytes, data};
                recent_bytes = window[RECENT_W-1:0];
                if (byte_position >= MAX_STRING_BYTES)
                begin
                    overflow_seen = 1'b1;
                    if (ending)
                        push_segment(segment_begin, byte_position - segment_begin, 1'b1);
                end
                else
                begin
                    span     = delim_span();
                    next_pos = byte_position + 1;
                    hit      = !overflow_seen && (next_pos - segment_begin >= span);
                    for (i = 0; i < span; i++)
                        if (delim_bytes[8*i +: 8] != window[8*(span-1-i) +: 8])
                            hit = 1'b0;
                    if (hit)
                    begin
                        push_segment(segment_begin, next_pos - span - segment_begin, ending);
                        segment_begin = next_pos;
                    end
                    else if (ending)
                    begin
                        push_segment(segment_begin, next_pos - segment_begin, 1'b1);
                    end
                    byte_position = next_pos;
                end
            end
            else if (ending)
            begin
                push_segment(segment_begin, byte_position - segment_begin, 1'b1);
            end
            if (ending)
                clear_string();
        endfunction

        function void check_segment(seg_result_t got);
            seg_result_t want;
            if (expected_segments.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected segment: start=%0d length=%0d last=%0b too_long=%0b",
                             got.start, got.length, got.last, got.too_long);
                return;
            end
            want = expected_segments.pop_front();
            if (got != want)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("segment mismatch: expected start=%0d length=%0d last=%0b too_long=%0b",
                             want.start, want.length, want.last, want.too_long);
                    $display("                  got      start=%0d length=%0d last=%0b too_long=%0b",
                             got.start, got.length, got.last, got.too_long);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_segments.size();
        endfunction
    endclass

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_DELIM_BYTES;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    segment_scoreboard sb;
    bit                steady       = 1'b0;
    int unsigned       holds_asked  = 0;
    int unsigned       holds_served = 0;
    int unsigned       quiet_cycles = 0;

    multibyte_delimiter_splitter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        seg_result_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.start    = m_axis_tdata[15:0];
                got.length   = m_axis_tdata[32:16];
                got.last     = m_axis_tlast;
                got.too_long = m_axis_tuser;
                sb.check_segment(got);
            end
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Downstream side: random stalls (none in steady mode), plus a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    task automatic send_item(input logic [7:0] data, input logic present, input logic ending);
        if (!steady)
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= present;
        s_axis_tlast  <= ending;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_text(input string text);
        int i;
        if (text.len() == 0)
            send_item(8'h00, 1'b0, 1'b1);
        for (i = 0; i < text.len(); i++)
            send_item(text[i], 1'b1, i == text.len() - 1);
    endtask

    // The extra clock lets the monitor note the last accepted transaction first.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_delimiter(input logic [CFG_W-1:0] bytes, input logic [CFG_W-1:0] length);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DELIM_BYTES;
        cfg_data  <= bytes;
        sb.write_reg(REG_DELIM_BYTES, bytes);
        @(posedge clk);
        cfg_index <= REG_DELIM_LENGTH;
        cfg_data  <= length;
        sb.write_reg(REG_DELIM_LENGTH, length);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Strings are mostly built from delimiter pieces, broken delimiter
    // prefixes and delimiter bytes, so that matches and near misses are common.
    task automatic send_random_strings(input int unsigned quota);
        text_item_t  items[$];
        text_item_t  item;
        int unsigned sent;
        int unsigned span;
        int unsigned target;
        int unsigned i;
        int unsigned cut;
        logic [7:0]  extra;
        sent = 0;
        span = sb.delim_span();
        while (sent < quota)
        begin
            items.delete();
            extra  = 8'($urandom_range(0, 255));
            target = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                 : $urandom_range(0, 20);
            while (items.size() < target)
            begin
                item.present = 1'b1;
                item.ending  = 1'b0;
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        for (i = 0; i < span; i++)
                        begin
                            item.data = sb.delim_bytes[8*i +: 8];
                            items.push_back(item);
                        end
                    end
                    2:
                    begin
                        cut = (span > 1) ? $urandom_range(1, span - 1) : 1;
                        for (i = 0; i < cut; i++)
                        begin
                            item.data = sb.delim_bytes[8*i +: 8];
                            items.push_back(item);
                        end
                    end
                    3, 4, 5:
                    begin
                        item.data = ($urandom_range(0, 3) == 0) ? extra
                                  : sb.delim_bytes[8*$urandom_range(0, span - 1) +: 8];
                        items.push_back(item);
                    end
                    6, 7:
                    begin
                        item.data = 8'($urandom_range(0, 255));
                        items.push_back(item);
                    end
                    8:
                    begin
                        item.data    = 8'($urandom_range(0, 255));
                        item.present = 1'b0;
                        items.push_back(item);
                    end
                    default:
                    begin
                        cut = $urandom_range(1, 3);
                        item.data = sb.delim_bytes[7:0];
                        for (i = 0; i < cut; i++)
                            items.push_back(item);
                    end
                endcase
            end
            if (items.size() == 0 || $urandom_range(0, 3) == 0)
            begin
                item.data    = 8'($urandom_range(0, 255));
                item.present = 1'b0;
                item.ending  = 1'b1;
                items.push_back(item);
            end
            else
            begin
                items[items.size() - 1].ending = 1'b1;
            end
            foreach (items[k])
            begin
                send_item(items[k].data, items[k].present, items[k].ending);
                if (items[k].present || items[k].ending)
                    sent++;
            end
        end
    endtask

    initial
    begin
        int unsigned      p;
        int unsigned      i;
        logic [CFG_W-1:0] bytes;
        logic [CFG_W-1:0] length;

        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Delimiter after reset is a single space.
        send_text("");
        send_text("ab c");
        send_text("x ");
        send_text("  ");
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h20, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        settle();

        set_delimiter(64'h6161, 64'h2);
        send_text("aaab");
        send_text("baaaa");
        send_text("aa");
        settle();

        for (p = 0; p < 10; p++)
        begin
            bytes  = {$urandom(), $urandom()};
            length = {$urandom(), $urandom()};
            for (i = 1; i < 8; i++)
                if ($urandom_range(0, 2) == 0)
                    bytes[8*i +: 8] = bytes[8*(i-1) +: 8];
            case (p)
                0:
                begin
                    bytes  = '1;
                    length = 64'd8;
                end
                1:
                begin
                    bytes  = '0;
                    length = '0;
                end
                2: length[3:0] = 4'd15;
                3: length[3:0] = 4'd1;
                default: length[3:0] = 4'($urandom_range(0, 15));
            endcase
            set_delimiter(bytes, length);
            if (p == 2 || p == 7)
                holds_asked <= holds_asked + 1;
            steady <= (p == 5);
            @(posedge clk);
            send_random_strings(PHASE_ITEMS);
            settle();
        end

        // A delimiter that ends exactly at the length limit, then bytes past it.
        set_delimiter(64'h0A0D, 64'h2);
        for (i = 0; i < MAX_STRING_BYTES - 2; i++)
            send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b1, 1'b0);
        send_item(8'h0D, 1'b1, 1'b0);
        send_item(8'h0A, 1'b1, 1'b0);
        send_item(8'h0D, 1'b1, 1'b0);
        send_item(8'h0A, 1'b1, 1'b0);
        send_item(8'h79, 1'b1, 1'b1);
        for (i = 0; i < MAX_STRING_BYTES; i++)
            send_item(8'($urandom_range(8'h20, 8'h7E)), 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        settle();
        repeat (10) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

/* multibyte_delimiter_splitter_unit.f */
rtl/mds_pkg.sv
rtl/mds_match.sv
rtl/mds_core.sv
rtl/multibyte_delimiter_splitter_unit.sv
rtl/mds_checker.sv
verif/tb_top.sv
